// ----- sv/assert_macros.svh -----
// Assertion macros used by the homography point transform RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define HPT_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hpt assertion failed");

// Next-cycle implication, disabled while reset is held.
`define HPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hpt assertion failed");

`endif

// ----- sv/hpt_pkg.sv -----
// Package: widths, register indexes and pipeline payload types of the point transform.
`default_nettype none
package hpt_pkg;

    localparam int COORD_BITS = 12;
    localparam int COEF_W     = 48;
    localparam int NUM_COEF   = 8;
    localparam int CFG_IDX_W  = 4;
    localparam int OUT_W      = 32;
    localparam int PROD_W     = COEF_W + COORD_BITS + 1;
    localparam int SUM_W      = PROD_W + 2;
    localparam int MAG_W      = SUM_W;
    localparam int FRAC_SHIFT = 17;
    localparam int QUO_W      = 34;
    localparam int REM_W      = MAG_W + QUO_W;

    localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1) << 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        COEF_00 = 4'd0,
        COEF_01 = 4'd1,
        COEF_02 = 4'd2,
        COEF_10 = 4'd3,
        COEF_11 = 4'd4,
        COEF_12 = 4'd5,
        COEF_20 = 4'd6,
        COEF_21 = 4'd7
    } t_coef_idx;

    typedef struct packed {
        logic signed [COEF_W-1:0] c00;
        logic signed [COEF_W-1:0] c01;
        logic signed [COEF_W-1:0] c02;
        logic signed [COEF_W-1:0] c10;
        logic signed [COEF_W-1:0] c11;
        logic signed [COEF_W-1:0] c12;
        logic signed [COEF_W-1:0] c20;
        logic signed [COEF_W-1:0] c21;
    } t_coef_set;

    typedef struct packed {
        logic [REM_W-1:0] rem_x;
        logic [REM_W-1:0] rem_y;
        logic [REM_W-1:0] dvs;
        logic [QUO_W-1:0] q_x;
        logic [QUO_W-1:0] q_y;
        logic             neg_x;
        logic             neg_y;
        logic             ovf_x;
        logic             ovf_y;
        logic             zero;
    } t_div_pl;

endpackage
`default_nettype wire

// ----- sv/hpt_matmul.sv -----
// Matrix front end: products, row sums, magnitudes and divider setup in four stages.
`default_nettype none
module hpt_matmul (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_en,
    input  wire                              i_valid,
    input  wire [hpt_pkg::COORD_BITS-1:0]    i_pixel_x,
    input  wire [hpt_pkg::COORD_BITS-1:0]    i_pixel_y,
    input  hpt_pkg::t_coef_set               i_coef,
    output logic                             o_valid,
    output hpt_pkg::t_div_pl                 o_pl
);

    localparam logic signed [hpt_pkg::SUM_W-1:0] W_ONE = hpt_pkg::SUM_W'(1) << 32;

    logic r_v1, r_v2, r_v3;
    logic signed [hpt_pkg::PROD_W-1:0] r_p00, r_p01, r_p10, r_p11, r_p20, r_p21;
    logic signed [hpt_pkg::PROD_W-1:0] n_p00, n_p01, n_p10, n_p11, n_p20, n_p21;
    logic signed [hpt_pkg::SUM_W-1:0]  r_sx, r_sy, r_sd, n_sx, n_sy, n_sd;
    logic [hpt_pkg::MAG_W-1:0]         r_mx, r_my, r_md, n_mx, n_my, n_md;
    logic                              r_nx, r_ny, r_zero;
    logic signed [hpt_pkg::COORD_BITS:0] w_x, w_y;
    hpt_pkg::t_div_pl                  r_pl, n_pl;
    logic                              r_v4;

    // Stage 1: six coefficient products
    always_comb begin
        w_x   = $signed({1'b0, i_pixel_x});
        w_y   = $signed({1'b0, i_pixel_y});
        n_p00 = i_coef.c00 * w_x;
        n_p01 = i_coef.c01 * w_y;
        n_p10 = i_coef.c10 * w_x;
        n_p11 = i_coef.c11 * w_y;
        n_p20 = i_coef.c20 * w_x;
        n_p21 = i_coef.c21 * w_y;
    end

    // Stage 2: row sums with constant terms
    always_comb begin
        n_sx = r_p00 + r_p01 + hpt_pkg::SUM_W'(i_coef.c02);
        n_sy = r_p10 + r_p11 + hpt_pkg::SUM_W'(i_coef.c12);
        n_sd = r_p20 + r_p21 + W_ONE;
    end

    // Stage 3: magnitudes
    always_comb begin
        n_mx = r_sx[hpt_pkg::SUM_W-1] ? hpt_pkg::MAG_W'(-r_sx) : hpt_pkg::MAG_W'(r_sx);
        n_my = r_sy[hpt_pkg::SUM_W-1] ? hpt_pkg::MAG_W'(-r_sy) : hpt_pkg::MAG_W'(r_sy);
        n_md = r_sd[hpt_pkg::SUM_W-1] ? hpt_pkg::MAG_W'(-r_sd) : hpt_pkg::MAG_W'(r_sd);
    end

    // Stage 4: scale numerators, align divisor, flag quotients that overflow
    always_comb begin
        n_pl.rem_x = hpt_pkg::REM_W'(r_mx) << hpt_pkg::FRAC_SHIFT;
        n_pl.rem_y = hpt_pkg::REM_W'(r_my) << hpt_pkg::FRAC_SHIFT;
        n_pl.dvs   = hpt_pkg::REM_W'(r_md) << (hpt_pkg::QUO_W - 1);
        n_pl.q_x   = '0;
        n_pl.q_y   = '0;
        n_pl.neg_x = r_nx;
        n_pl.neg_y = r_ny;
        n_pl.ovf_x = n_pl.rem_x >= (hpt_pkg::REM_W'(r_md) << hpt_pkg::QUO_W);
        n_pl.ovf_y = n_pl.rem_y >= (hpt_pkg::REM_W'(r_md) << hpt_pkg::QUO_W);
        n_pl.zero  = r_zero;
    end

    // Advance payload on enable
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p00  <= n_p00;
            r_p01  <= n_p01;
            r_p10  <= n_p10;
            r_p11  <= n_p11;
            r_p20  <= n_p20;
            r_p21  <= n_p21;
            r_sx   <= n_sx;
            r_sy   <= n_sy;
            r_sd   <= n_sd;
            r_mx   <= n_mx;
            r_my   <= n_my;
            r_md   <= n_md;
            r_nx   <= r_sx[hpt_pkg::SUM_W-1] ^ r_sd[hpt_pkg::SUM_W-1];
            r_ny   <= r_sy[hpt_pkg::SUM_W-1] ^ r_sd[hpt_pkg::SUM_W-1];
            r_zero <= (r_sd == '0);
            r_pl   <= n_pl;
        end
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    assign o_valid = r_v4;
    assign o_pl    = r_pl;

endmodule
`default_nettype wire

// ----- sv/hpt_div_step.sv -----
// One restoring division step: one quotient bit for both x and y.
`default_nettype none
module hpt_div_step (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_en,
    input  wire               i_valid,
    input  hpt_pkg::t_div_pl  i_pl,
    output logic              o_valid,
    output hpt_pkg::t_div_pl  o_pl
);

    hpt_pkg::t_div_pl r_pl, n_pl;
    logic             r_v;
    logic             w_gx, w_gy;

    // Compare, subtract and shift in one quotient bit
    always_comb begin
        w_gx       = i_pl.rem_x >= i_pl.dvs;
        w_gy       = i_pl.rem_y >= i_pl.dvs;
        n_pl       = i_pl;
        n_pl.rem_x = w_gx ? i_pl.rem_x - i_pl.dvs : i_pl.rem_x;
        n_pl.rem_y = w_gy ? i_pl.rem_y - i_pl.dvs : i_pl.rem_y;
        n_pl.q_x   = {i_pl.q_x[hpt_pkg::QUO_W-2:0], w_gx};
        n_pl.q_y   = {i_pl.q_y[hpt_pkg::QUO_W-2:0], w_gy};
        n_pl.dvs   = i_pl.dvs >> 1;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pl <= n_pl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_valid;
        end
    end

    assign o_valid = r_v;
    assign o_pl    = r_pl;

endmodule
`default_nettype wire

// ----- sv/homography_point_transform.sv -----
// Homography point transform: pipelined 3x3 perspective mapping of pixel points.
//
// Usage: an input beat (pixel_x, pixel_y) is taken when i_valid is high and
// o_stall is low. A result beat (mapped_x, mapped_y in signed Q16.16, plus
// zero_denominator and saturated flags) is delivered when o_valid is high and
// i_stall is low. The user must write coefficients through i_cfg_wr_en /
// i_cfg_index / i_cfg_wr_data only while no point is in flight; the block does
// not enforce this. Indexes past the eighth are ignored. Throughput: one point
// per clock while not stalled. From accept to o_valid: four matrix stages, 34
// divider stages (one quotient bit each, shared divisor for x and y) and one
// rounding/saturation output stage. Reset (synchronous, active low) empties the
// pipeline and loads the identity matrix. While the receiver stalls a waiting
// result, o_stall is raised in the same cycle and every stage holds, empty
// stages included; nothing advances until the result beat is taken.
`default_nettype none
`include "assert_macros.svh"
module homography_point_transform (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_valid,
    output logic                             o_stall,
    input  wire [hpt_pkg::COORD_BITS-1:0]    i_pixel_x,
    input  wire [hpt_pkg::COORD_BITS-1:0]    i_pixel_y,
    output logic                             o_valid,
    input  wire                              i_stall,
    output logic signed [hpt_pkg::OUT_W-1:0] o_mapped_x,
    output logic signed [hpt_pkg::OUT_W-1:0] o_mapped_y,
    output logic                             o_zero_denominator,
    output logic                             o_saturated,
    input  wire                              i_cfg_wr_en,
    input  wire [hpt_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire [hpt_pkg::COEF_W-1:0]        i_cfg_wr_data
);

    localparam logic [hpt_pkg::QUO_W-1:0] LIM_POS =
        (hpt_pkg::QUO_W'(1) << (hpt_pkg::OUT_W - 1)) - hpt_pkg::QUO_W'(1);
    localparam logic [hpt_pkg::QUO_W-1:0] LIM_NEG =
        hpt_pkg::QUO_W'(1) << (hpt_pkg::OUT_W - 1);
    localparam logic [hpt_pkg::OUT_W-1:0] SAT_POS = LIM_POS[hpt_pkg::OUT_W-1:0];
    localparam logic [hpt_pkg::OUT_W-1:0] SAT_NEG = LIM_NEG[hpt_pkg::OUT_W-1:0];

    hpt_pkg::t_coef_set r_coef;
    logic               w_en;
    logic [hpt_pkg::QUO_W:0] w_v;
    hpt_pkg::t_div_pl   w_pl [hpt_pkg::QUO_W+1];

    logic                       r_out_v, r_zero, r_sat;
    logic [hpt_pkg::OUT_W-1:0]  r_mx, r_my, n_mx, n_my;
    logic                       n_sat_x, n_sat_y;
    logic [hpt_pkg::QUO_W:0]    w_rx, w_ry;
    logic [hpt_pkg::QUO_W-1:0]  w_qx, w_qy;
    hpt_pkg::t_div_pl           w_last;
    logic                       w_clr_ok, w_clamp_ok;

    // Hold everything while a result waits on a stalled receiver
    assign w_en    = !(r_out_v && i_stall);
    assign o_stall = !w_en;

    // Coefficient registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef.c00 <= hpt_pkg::COEF_ONE;
            r_coef.c01 <= '0;
            r_coef.c02 <= '0;
            r_coef.c10 <= '0;
            r_coef.c11 <= hpt_pkg::COEF_ONE;
            r_coef.c12 <= '0;
            r_coef.c20 <= '0;
            r_coef.c21 <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                hpt_pkg::COEF_00: r_coef.c00 <= i_cfg_wr_data;
                hpt_pkg::COEF_01: r_coef.c01 <= i_cfg_wr_data;
                hpt_pkg::COEF_02: r_coef.c02 <= i_cfg_wr_data;
                hpt_pkg::COEF_10: r_coef.c10 <= i_cfg_wr_data;
                hpt_pkg::COEF_11: r_coef.c11 <= i_cfg_wr_data;
                hpt_pkg::COEF_12: r_coef.c12 <= i_cfg_wr_data;
                hpt_pkg::COEF_20: r_coef.c20 <= i_cfg_wr_data;
                hpt_pkg::COEF_21: r_coef.c21 <= i_cfg_wr_data;
                default: ;
            endcase
        end
    end

    hpt_matmul u_matmul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (i_valid),
        .i_pixel_x (i_pixel_x),
        .i_pixel_y (i_pixel_y),
        .i_coef    (r_coef),
        .o_valid   (w_v[0]),
        .o_pl      (w_pl[0])
    );

    // Divider chain, most significant quotient bit first
    for (genvar k = 0; k < hpt_pkg::QUO_W; k++) begin : g_div
        hpt_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_v[k]),
            .i_pl    (w_pl[k]),
            .o_valid (w_v[k+1]),
            .o_pl    (w_pl[k+1])
        );
    end

    // Round half away from zero, clamp, apply sign
    always_comb begin
        w_last  = w_pl[hpt_pkg::QUO_W];
        w_rx    = {1'b0, w_last.q_x} + (hpt_pkg::QUO_W+1)'(1);
        w_ry    = {1'b0, w_last.q_y} + (hpt_pkg::QUO_W+1)'(1);
        w_qx    = w_rx[hpt_pkg::QUO_W:1];
        w_qy    = w_ry[hpt_pkg::QUO_W:1];
        n_sat_x = w_last.ovf_x || (w_last.neg_x ? (w_qx > LIM_NEG) : (w_qx > LIM_POS));
        n_sat_y = w_last.ovf_y || (w_last.neg_y ? (w_qy > LIM_NEG) : (w_qy > LIM_POS));
        if (n_sat_x) begin
            n_mx = w_last.neg_x ? SAT_NEG : SAT_POS;
        end else begin
            n_mx = w_last.neg_x ? -w_qx[hpt_pkg::OUT_W-1:0] : w_qx[hpt_pkg::OUT_W-1:0];
        end
        if (n_sat_y) begin
            n_my = w_last.neg_y ? SAT_NEG : SAT_POS;
        end else begin
            n_my = w_last.neg_y ? -w_qy[hpt_pkg::OUT_W-1:0] : w_qy[hpt_pkg::OUT_W-1:0];
        end
        if (w_last.zero) begin
            n_mx = '0;
            n_my = '0;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mx   <= n_mx;
            r_my   <= n_my;
            r_zero <= w_last.zero;
            r_sat  <= (n_sat_x || n_sat_y) && !w_last.zero;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_out_v <= w_v[hpt_pkg::QUO_W];
        end
    end

    assign o_valid            = r_out_v;
    assign o_mapped_x         = r_mx;
    assign o_mapped_y         = r_my;
    assign o_zero_denominator = r_zero;
    assign o_saturated        = r_sat;

    // Checks on the result beat
    assign w_clr_ok   = o_mapped_x == '0 && o_mapped_y == '0 && !o_saturated;
    assign w_clamp_ok = o_mapped_x == SAT_POS || o_mapped_x == SAT_NEG ||
                        o_mapped_y == SAT_POS || o_mapped_y == SAT_NEG;

    // A zero denominator yields cleared outputs and no saturation
    `HPT_ASSERT_IMPLY(a_zero_clear, i_clk, i_rst_n, o_valid && o_zero_denominator, w_clr_ok)
    // A saturated result carries a clamp value in at least one output
    `HPT_ASSERT_IMPLY(a_sat_clamp, i_clk, i_rst_n, o_valid && o_saturated, w_clamp_ok)
    // A held pipeline keeps its last divider stage in place
    `HPT_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_stall, $stable(w_v[hpt_pkg::QUO_W]))

endmodule
`default_nettype wire
